FILE: hw/rtl/efpf_pkg.sv
package efpf_pkg;

  // link framing bytes
  localparam logic [7:0] HEADER_BYTE = 8'h47;
  localparam logic [7:0] LINE_FEED   = 8'h0A;

  // frame layout: position bytes and shortest usable frame
  localparam int unsigned POS_FIRST_IDX   = 2;
  localparam int unsigned POS_LAST_IDX    = 5;
  localparam int unsigned MIN_FRAME_BYTES = 6;

  // datapath widths
  localparam int unsigned POS_W   = 32;
  localparam int unsigned ANGLE_W = 35;
  localparam int unsigned DPT_W   = 24;
  localparam int unsigned PROD_W  = POS_W + DPT_W;
  localparam int unsigned MAG_W   = PROD_W - 7;
  localparam int unsigned ACC_W   = MAG_W + 2;
  localparam int unsigned WRAP_W  = 25;

  // angle constants, Q.16 degrees
  localparam logic [WRAP_W-1:0]       FULL_TURN_Q16 = 25'd23592960;
  localparam logic signed [ACC_W-1:0] ANGLE_MAX     = 51'sd17179869183;
  localparam logic signed [ACC_W-1:0] ANGLE_MIN     = -51'sd17179869184;
  localparam logic [PROD_W:0]         ROUND_HALF    = 57'd128;

  typedef enum logic [1:0] {
    OUT_UPDATED = 2'd0,
    OUT_NOISE   = 2'd1,
    OUT_JUMP    = 2'd2,
    OUT_SHORT   = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    REG_AXIS_MODE        = 3'd0,
    REG_HOME_TICKS       = 3'd1,
    REG_DEGREES_PER_TICK = 3'd2,
    REG_HOME_DEGREES     = 3'd3,
    REG_NOISE_TOLERANCE  = 3'd4,
    REG_JUMP_LIMIT       = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic        axis_mode;
    logic [23:0] home_ticks;
    logic [23:0] degrees_per_tick;
    logic [24:0] home_degrees;
    logic [15:0] noise_tolerance;
    logic [15:0] jump_limit;
  } cfg_t;

  // register reset values
  localparam logic        RST_AXIS_MODE        = 1'b0;
  localparam logic [23:0] RST_HOME_TICKS       = 24'd221329;
  localparam logic [23:0] RST_DEGREES_PER_TICK = 24'd82850;
  localparam logic [24:0] RST_HOME_DEGREES     = 25'd5859172;
  localparam logic [15:0] RST_NOISE_TOLERANCE  = 16'd0;
  localparam logic [15:0] RST_JUMP_LIMIT       = 16'd2000;

  // completed frame from the framer
  typedef struct packed {
    logic             short_frame;
    logic [POS_W-1:0] pos;
  } frame_t;

  // filter decision handed to the angle pipeline
  typedef struct packed {
    logic [POS_W-1:0] pos;
    outcome_e         outcome;
    logic             updated;
  } filt_t;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: hw/rtl/encoder_frame_position_filter.sv
// Path: the frame register loads on the edge that accepts the byte closing its frame, then
// the filter register, three angle stages and the output register take the result in turn.
// Throughput: one byte per cycle; stalls only when the pipeline ahead is full.
// The 32x24 multiply in the angle pipeline sets the stage depth.
// Reset (rst_ni low, asynchronous): framer idle, accepted and published position and
// angle cleared, configuration registers at their documented reset values.
module encoder_frame_position_filter import efpf_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] position, [66:32] angle, [71:67] zero
  output logic [1:0]  m_tuser,   // [1:0] outcome
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t   cfg;
  logic   frame_valid, frame_ready;
  frame_t frame;
  logic   filt_valid, filt_ready;
  filt_t  filt;
  logic [POS_W-1:0]          position;
  logic signed [ANGLE_W-1:0] angle;
  outcome_e                  outcome;

  efpf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  efpf_framer #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (s_tvalid),
    .byte_i        (s_tdata),
    .byte_ready_o  (s_tready),
    .frame_valid_o (frame_valid),
    .frame_o       (frame),
    .frame_ready_i (frame_ready)
  );

  efpf_filter u_filter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .res_valid_o   (filt_valid),
    .res_o         (filt),
    .res_ready_i   (filt_ready)
  );

  efpf_angle u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (filt_valid),
    .in_i        (filt),
    .in_ready_o  (filt_ready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .position_o  (position),
    .angle_o     (angle),
    .outcome_o   (outcome)
  );

  // result packing
  assign m_tdata = {5'b0, angle, position};
  assign m_tuser = outcome;

`ifndef ASSERT_OFF
  // input is held back only by a pending frame
  a_ready_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> frame_valid)
    else $error("input stalled with no pending frame");

  // a new frame appears only right after an accepted byte
  a_frame_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(frame_valid) |-> $past(s_tvalid && s_tready))
    else $error("frame raised without an accepted byte");

  // a short frame never moves the filter into updating
  a_short_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filt_valid && filt.outcome == OUT_SHORT |-> !filt.updated)
    else $error("short frame marked as update");
`endif

endmodule

FILE: hw/rtl/efpf_regs.sv
module efpf_regs import efpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_mode        <= RST_AXIS_MODE;
      cfg_q.home_ticks       <= RST_HOME_TICKS;
      cfg_q.degrees_per_tick <= RST_DEGREES_PER_TICK;
      cfg_q.home_degrees     <= RST_HOME_DEGREES;
      cfg_q.noise_tolerance  <= RST_NOISE_TOLERANCE;
      cfg_q.jump_limit       <= RST_JUMP_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_AXIS_MODE:        cfg_q.axis_mode        <= pwdata[0];
        REG_HOME_TICKS:       cfg_q.home_ticks       <= pwdata[23:0];
        REG_DEGREES_PER_TICK: cfg_q.degrees_per_tick <= pwdata[23:0];
        REG_HOME_DEGREES:     cfg_q.home_degrees     <= pwdata[24:0];
        REG_NOISE_TOLERANCE:  cfg_q.noise_tolerance  <= pwdata[15:0];
        REG_JUMP_LIMIT:       cfg_q.jump_limit       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_AXIS_MODE:        prdata = {31'b0, cfg_q.axis_mode};
      REG_HOME_TICKS:       prdata = {8'b0, cfg_q.home_ticks};
      REG_DEGREES_PER_TICK: prdata = {8'b0, cfg_q.degrees_per_tick};
      REG_HOME_DEGREES:     prdata = {7'b0, cfg_q.home_degrees};
      REG_NOISE_TOLERANCE:  prdata = {16'b0, cfg_q.noise_tolerance};
      REG_JUMP_LIMIT:       prdata = {16'b0, cfg_q.jump_limit};
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/efpf_framer.sv
module efpf_framer import efpf_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       byte_ready_o,
  output logic       frame_valid_o,
  output frame_t     frame_o,
  input  logic       frame_ready_i
);

  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(FRAME_BYTES);
  localparam logic [CW-1:0] MIN_CNT   = CW'(MIN_FRAME_BYTES);
  localparam logic [CW-1:0] POS_FIRST = CW'(POS_FIRST_IDX);
  localparam logic [CW-1:0] POS_LAST  = CW'(POS_LAST_IDX);
  localparam logic [CW-1:0] ONE_CNT   = CW'(1);

  logic [CW-1:0]    count_q, count_d, cnt_inc, end_cnt;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             fire, end_frame;
  logic             frame_valid_q;
  frame_t           frame_q;

  assign byte_ready_o  = !frame_valid_q || frame_ready_i;
  assign fire          = byte_valid_i && byte_ready_o;
  assign cnt_inc       = count_q + ONE_CNT;
  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

  // hunt for header, count bytes, collect the position bytes
  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    end_frame = 1'b0;
    end_cnt   = count_q;
    if (fire) begin
      if (count_q == '0) begin
        if (byte_i == HEADER_BYTE) count_d = ONE_CNT;
      end else if (byte_i != LINE_FEED) begin
        if (count_q >= POS_FIRST && count_q <= POS_LAST) begin
          pos_d = {pos_q[POS_W-9:0], byte_i};
        end
        if (cnt_inc == FULL_CNT) begin
          end_frame = 1'b1;
          end_cnt   = cnt_inc;
          count_d   = '0;
        end else begin
          count_d = cnt_inc;
        end
      end else begin
        end_frame = 1'b1;
        count_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      frame_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (end_frame) begin
        frame_valid_q <= 1'b1;
      end else if (frame_ready_i) begin
        frame_valid_q <= 1'b0;
      end
    end
  end

  // position bytes and frame register
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (end_frame) begin
      frame_q.short_frame <= (end_cnt < MIN_CNT);
      frame_q.pos         <= pos_q;
    end
  end

endmodule

FILE: hw/rtl/efpf_filter.sv
module efpf_filter import efpf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   frame_valid_i,
  input  frame_t frame_i,
  output logic   frame_ready_o,
  output logic   res_valid_o,
  output filt_t  res_o,
  input  logic   res_ready_i
);

  logic [POS_W-1:0] acc_q, pub_q;
  logic [POS_W-1:0] acc_new, jump_diff, pub_diff;
  logic             jump, noisy, take;
  logic             res_valid_q;
  filt_t            res_q, res_d;

  assign frame_ready_o = !res_valid_q || res_ready_i;
  assign take          = frame_valid_i && frame_ready_o;
  assign res_valid_o   = res_valid_q;
  assign res_o         = res_q;

  // jump rejection, then noise gate against the published position
  always_comb begin
    jump_diff = abs_diff(acc_q, frame_i.pos);
    jump      = (acc_q != '0) && (jump_diff > {16'b0, cfg_i.jump_limit});
    acc_new   = jump ? acc_q : frame_i.pos;
    pub_diff  = abs_diff(pub_q, acc_new);
    noisy     = pub_diff > {16'b0, cfg_i.noise_tolerance};
    if (frame_i.short_frame) begin
      res_d.pos     = pub_q;
      res_d.outcome = OUT_SHORT;
      res_d.updated = 1'b0;
    end else begin
      res_d.pos     = noisy ? acc_new : pub_q;
      res_d.outcome = jump ? OUT_JUMP : (noisy ? OUT_UPDATED : OUT_NOISE);
      res_d.updated = noisy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pub_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (frame_ready_o) res_valid_q <= frame_valid_i;
      if (take && !frame_i.short_frame) begin
        acc_q <= acc_new;
        pub_q <= res_d.pos;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

endmodule

FILE: hw/rtl/efpf_angle.sv
module efpf_angle import efpf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  input  filt_t                     in_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [POS_W-1:0]          position_o,
  output logic signed [ANGLE_W-1:0] angle_o,
  output outcome_e                  outcome_o
);

  // stage 1: tick distance from home
  logic               s1_v;
  filt_t              s1_res;
  logic [POS_W-1:0]   s1_mag;
  logic               s1_neg;
  // stage 2: product in Q.24
  logic               s2_v;
  filt_t              s2_res;
  logic [PROD_W-1:0]  s2_prod;
  logic               s2_neg;
  // stage 3: rounded and signed angle before wrap
  logic               s3_v;
  filt_t              s3_res;
  logic signed [ACC_W-1:0] s3_a;
  logic [WRAP_W-1:0]  s3_w;
  // output register
  logic               out_v;
  logic [POS_W-1:0]   pos_q;
  logic signed [ANGLE_W-1:0] angle_q;
  outcome_e           outcome_q;

  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic [POS_W-1:0]        home_ext;
  logic [PROD_W:0]         rnd;
  logic [MAG_W-1:0]        m;
  logic signed [ACC_W-1:0] m_ext, h_ext, a_d, w_ext, wrapped, sat;

  assign out_ready  = !out_v || out_ready_i;
  assign s3_ready   = !s3_v || out_ready;
  assign s2_ready   = !s2_v || s3_ready;
  assign s1_ready   = !s1_v || s2_ready;
  assign in_ready_o = s1_ready;

  assign out_valid_o = out_v;
  assign position_o  = pos_q;
  assign angle_o     = angle_q;
  assign outcome_o   = outcome_q;

  assign home_ext = {8'b0, cfg_i.home_ticks};

  // round Q.24 to Q.16 and apply the axis rule
  always_comb begin
    rnd   = {1'b0, s2_prod} + ROUND_HALF;
    m     = rnd[PROD_W:8];
    m_ext = signed'({2'b0, m});
    h_ext = signed'({{(ACC_W-WRAP_W){1'b0}}, cfg_i.home_degrees});
    if (!cfg_i.axis_mode) begin
      a_d = s2_neg ? -m_ext : m_ext;
    end else begin
      a_d = h_ext - m_ext;
    end
  end

  // wrap into range, then clamp to the output width
  always_comb begin
    w_ext = signed'({{(ACC_W-WRAP_W){1'b0}}, s3_w});
    if (s3_a > w_ext) begin
      wrapped = s3_a - w_ext;
    end else if (s3_a < 0) begin
      wrapped = s3_a + w_ext;
    end else begin
      wrapped = s3_a;
    end
    if (wrapped > ANGLE_MAX) begin
      sat = ANGLE_MAX;
    end else if (wrapped < ANGLE_MIN) begin
      sat = ANGLE_MIN;
    end else begin
      sat = wrapped;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
      out_v   <= 1'b0;
      angle_q <= '0;
    end else begin
      if (s1_ready)  s1_v  <= in_valid_i;
      if (s2_ready)  s2_v  <= s1_v;
      if (s3_ready)  s3_v  <= s2_v;
      if (out_ready) out_v <= s3_v;
      // published angle is held in the output register
      if (s3_v && out_ready && s3_res.updated) angle_q <= sat[ANGLE_W-1:0];
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_res <= in_i;
      s1_mag <= abs_diff(home_ext, in_i.pos);
      s1_neg <= in_i.pos > home_ext;
    end
    if (s1_v && s2_ready) begin
      s2_res  <= s1_res;
      s2_prod <= PROD_W'(s1_mag) * PROD_W'(cfg_i.degrees_per_tick);
      s2_neg  <= s1_neg;
    end
    if (s2_v && s3_ready) begin
      s3_res <= s2_res;
      s3_a   <= a_d;
      s3_w   <= cfg_i.axis_mode ? cfg_i.home_degrees : FULL_TURN_Q16;
    end
    if (s3_v && out_ready) begin
      pos_q     <= s3_res.pos;
      outcome_q <= s3_res.outcome;
    end
  end

endmodule
